>>> hdl/trbd_pkg.sv
// shared types, constants and helpers of the transparent-run bitmap decoder
// no dependencies; imported by every module of the block
package trbd_pkg;

	// largest line count and line length that the decoder honors
	localparam int MAX_DIM = 1024;

	// depth of the queue between the front and the back part
	localparam int QDEPTH = 2;

	// result kinds
	localparam logic [1:0] KIND_PIXEL = 2'd0;
	localparam logic [1:0] KIND_SPAN  = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// command phases in holes mode
	localparam logic [1:0] PH_HIGH = 2'd0;
	localparam logic [1:0] PH_LOW  = 2'd1;
	localparam logic [1:0] PH_LIT  = 2'd2;

	// register indexes of the configuration port
	localparam logic [1:0] REG_LINES   = 2'd0;
	localparam logic [1:0] REG_PPL     = 2'd1;
	localparam logic [1:0] REG_COLUMN  = 2'd2;
	localparam logic [1:0] REG_HOLES   = 2'd3;

	// effective configuration, dimensions already clamped
	typedef struct packed {
		logic [10:0] lines;
		logic [10:0] ppl;
		logic        column_major;
		logic        holes_mode;
	} cfg_t;

	// one decoded result before address generation
	typedef struct packed {
		logic [1:0]  kind;
		logic [10:0] line;
		logic [10:0] pix;
		logic [10:0] count;
		logic [7:0]  value;
		logic        lend;
		logic        iend;
	} res_t;

	// zero acts as one, anything above MAX_DIM acts as MAX_DIM
	function automatic logic [10:0] clamp_dim(logic [10:0] v);
		logic [10:0] r;
		if (v == '0) begin
			r = 11'd1;
		end else if (32'(v) > 32'(MAX_DIM)) begin
			r = 11'(MAX_DIM);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

>>> hdl/transparent_run_bitmap_decoder_unit.sv
// Transparent-run bitmap decoder. Decodes one image's pixel byte stream, in plain
// or holes (skip/literal/end command) form, into pixel writes, zero-fill spans and
// sticky error beats with image-relative addresses in row- or column-major order.
// A byte is taken every cycle while the result queue is not full; a byte that yields
// a result is decoded into the queue at the edge that accepts it, then passes the
// multiply stage and the output register to show up on the output, and a two-entry
// queue between front and back lets either side stall on its own.
// Configuration registers sit on the APB port at 0x0 lines_per_image, 0x4
// pixels_per_line, 0x8 column_major, 0xC holes_mode; write them only while idle.
// Depends on trbd_pkg, trbd_front, trbd_queue and trbd_back.
module transparent_run_bitmap_decoder_unit import trbd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// byte input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        image_start,
	// result output
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [19:0] address,
	output logic [10:0] stride,
	output logic [10:0] span_count,
	output logic [7:0]  pixel_value,
	output logic [9:0]  line_index,
	output logic [10:0] pixel_index,
	output logic        line_end,
	output logic        image_end
);

	logic [10:0] lines_q, ppl_q;
	logic        column_q, holes_q;
	logic        wr_en;
	cfg_t        cfg;

	logic        in_fire;
	logic        res_valid;
	res_t        res;
	logic        q_push, q_pop, q_full, q_valid;
	res_t        q_head;

	// register file
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lines_q  <= 11'd1;
			ppl_q    <= 11'd1;
			column_q <= 1'b0;
			holes_q  <= 1'b0;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_LINES:  lines_q  <= pwdata[10:0];
				REG_PPL:    ppl_q    <= pwdata[10:0];
				REG_COLUMN: column_q <= pwdata[0];
				REG_HOLES:  holes_q  <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_LINES:  prdata = {21'd0, lines_q};
			REG_PPL:    prdata = {21'd0, ppl_q};
			REG_COLUMN: prdata = {31'd0, column_q};
			REG_HOLES:  prdata = {31'd0, holes_q};
		endcase
	end

	// effective configuration
	always_comb begin
		cfg.lines        = clamp_dim(lines_q);
		cfg.ppl          = clamp_dim(ppl_q);
		cfg.column_major = column_q;
		cfg.holes_mode   = holes_q;
	end

	// front
	assign in_ready = !q_full;
	assign in_fire  = in_valid && in_ready;
	assign q_push   = in_fire && res_valid;

	trbd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_fire     (in_fire),
		.data_byte   (data_byte),
		.image_start (image_start),
		.res_valid   (res_valid),
		.res         (res)
	);

	// result queue
	trbd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (res),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_valid),
		.head      (q_head)
	);

	// back
	trbd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.q_valid     (q_valid),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.address     (address),
		.stride      (stride),
		.span_count  (span_count),
		.pixel_value (pixel_value),
		.line_index  (line_index),
		.pixel_index (pixel_index),
		.line_end    (line_end),
		.image_end   (image_end)
	);

	// no push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push)
		else $error("result pushed into full queue");

	// a pixel beat always covers exactly one pixel
	a_pixel_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_PIXEL) |-> span_count == 11'd1)
		else $error("pixel beat with count other than one");

	// error beats carry no count and end nothing
	a_error_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_ERROR) |-> (span_count == '0 && !line_end && !image_end))
		else $error("malformed error beat");

	// the last line's result also ends its line
	a_image_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && image_end) |-> line_end)
		else $error("image end without line end");

endmodule

>>> hdl/trbd_front.sv
// front part: takes stream bytes, tracks line/pixel position and command phase
// and classifies each byte into at most one result; depends on trbd_pkg
module trbd_front import trbd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_fire,
	input  logic [7:0] data_byte,
	input  logic       image_start,
	output logic       res_valid,
	output res_t       res
);

	logic [10:0] line_q, pix_q, lit_q;
	logic [1:0]  phase_q;
	logic [7:0]  chigh_q;
	logic        err_q, done_q;

	logic [10:0] line_v, pix_v, lit_v;
	logic [1:0]  phase_v;
	logic [7:0]  chigh_v;
	logic        err_v, done_v;

	logic [10:0] line_n, pix_n, lit_n;
	logic [1:0]  phase_n;
	logic [7:0]  chigh_n;
	logic        err_n, done_n;

	logic [10:0] pix_inc, line_inc, lit_dec;
	logic [15:0] cmd;
	logic [16:0] run, run_sum;
	logic        run_over;

	// position and run arithmetic
	always_comb begin
		line_v  = image_start ? '0 : line_q;
		pix_v   = image_start ? '0 : pix_q;
		lit_v   = image_start ? '0 : lit_q;
		phase_v = image_start ? PH_HIGH : phase_q;
		chigh_v = image_start ? '0 : chigh_q;
		err_v   = image_start ? 1'b0 : err_q;
		done_v  = image_start ? 1'b0 : done_q;

		pix_inc  = pix_v + 11'd1;
		line_inc = line_v + 11'd1;
		lit_dec  = lit_v - 11'd1;
		cmd      = {chigh_v, data_byte};
		run      = cmd[15] ? (17'h10000 - {1'b0, cmd}) : {1'b0, cmd};
		run_sum  = {6'd0, pix_v} + run;
		run_over = run_sum > {6'd0, cfg.ppl};
	end

	// decode one byte
	always_comb begin
		line_n    = line_v;
		pix_n     = pix_v;
		lit_n     = lit_v;
		phase_n   = phase_v;
		chigh_n   = chigh_v;
		err_n     = err_v;
		done_n    = done_v;
		res_valid = 1'b0;
		res       = '0;
		res.line  = line_v;
		res.pix   = pix_v;

		if (!done_v) begin
			if (err_v) begin
				res_valid = 1'b1;
				res.kind  = KIND_ERROR;
			end else if (!cfg.holes_mode) begin
				// plain line: every byte is a pixel
				res_valid  = 1'b1;
				res.kind   = KIND_PIXEL;
				res.count  = 11'd1;
				res.value  = data_byte;
				res.lend   = pix_inc >= cfg.ppl;
				pix_n      = pix_inc;
				if (pix_inc >= cfg.ppl) begin
					line_n   = line_inc;
					pix_n    = '0;
					phase_n  = PH_HIGH;
					lit_n    = '0;
					done_n   = line_inc >= cfg.lines;
					res.iend = line_inc >= cfg.lines;
				end
			end else begin
				unique case (phase_v)
					PH_HIGH: begin
						chigh_n = data_byte;
						phase_n = PH_LOW;
					end
					PH_LIT: begin
						res_valid = 1'b1;
						res.kind  = KIND_PIXEL;
						res.count = 11'd1;
						res.value = data_byte;
						pix_n     = pix_inc;
						lit_n     = lit_dec;
						if (lit_dec == '0) begin
							phase_n = PH_HIGH;
						end
					end
					default: begin
						// low byte completes the command word
						phase_n = PH_HIGH;
						if (cmd == '0) begin
							res_valid = 1'b1;
							res.kind  = KIND_SPAN;
							res.count = (cfg.ppl > pix_v) ? cfg.ppl - pix_v : '0;
							res.lend  = 1'b1;
							res.iend  = line_inc >= cfg.lines;
							line_n    = line_inc;
							pix_n     = '0;
							lit_n     = '0;
							done_n    = line_inc >= cfg.lines;
						end else if (run_over) begin
							res_valid = 1'b1;
							res.kind  = KIND_ERROR;
							err_n     = 1'b1;
						end else if (cmd[15]) begin
							res_valid = 1'b1;
							res.kind  = KIND_SPAN;
							res.count = run[10:0];
							pix_n     = run_sum[10:0];
						end else begin
							lit_n   = cmd[10:0];
							phase_n = PH_LIT;
						end
					end
				endcase
			end
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q  <= '0;
			pix_q   <= '0;
			lit_q   <= '0;
			phase_q <= PH_HIGH;
			chigh_q <= '0;
			err_q   <= 1'b0;
			done_q  <= 1'b0;
		end else if (in_fire) begin
			line_q  <= line_n;
			pix_q   <= pix_n;
			lit_q   <= lit_n;
			phase_q <= phase_n;
			chigh_q <= chigh_n;
			err_q   <= err_n;
			done_q  <= done_n;
		end
	end

endmodule

>>> hdl/trbd_queue.sv
// short result queue between the front and the back part
// depends on trbd_pkg for res_t and the depth
module trbd_queue import trbd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_data,
	input  logic pop,
	output logic full,
	output logic not_empty,
	output res_t head
);

	localparam int QW = $clog2(QDEPTH);

	res_t          entry_q [QDEPTH];
	logic [QW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QW:0]   cnt_q;

	assign full      = cnt_q == (QW + 1)'(QDEPTH);
	assign not_empty = cnt_q != '0;
	assign head      = entry_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/trbd_back.sv
// back part: turns queued results into addressed output beats
// multiply stage, then add into the output register; depends on trbd_pkg
module trbd_back import trbd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        q_valid,
	input  res_t        q_head,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [19:0] address,
	output logic [10:0] stride,
	output logic [10:0] span_count,
	output logic [7:0]  pixel_value,
	output logic [9:0]  line_index,
	output logic [10:0] pixel_index,
	output logic        line_end,
	output logic        image_end
);

	logic        valid_s1;
	res_t        res_s1;
	logic [21:0] prod_s1;
	logic [10:0] addend_s1;
	logic [10:0] stride_s1;
	logic        adv_s1;

	assign adv_s1 = valid_s1 && (!out_valid || out_ready);
	assign q_pop  = q_valid && (!valid_s1 || adv_s1);

	// stage 1: line or pixel product
	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_s1    <= q_head;
			prod_s1   <= cfg.column_major ? cfg.lines * q_head.pix : q_head.line * cfg.ppl;
			addend_s1 <= cfg.column_major ? q_head.line : q_head.pix;
			stride_s1 <= cfg.column_major ? cfg.lines : 11'd1;
		end
	end

	// output register: address sum
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			kind        <= res_s1.kind;
			address     <= 20'(prod_s1 + {11'd0, addend_s1});
			stride      <= stride_s1;
			span_count  <= res_s1.count;
			pixel_value <= res_s1.value;
			line_index  <= res_s1.line[9:0];
			pixel_index <= res_s1.pix;
			line_end    <= res_s1.lend;
			image_end   <= res_s1.iend;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (q_pop) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule
